FILE: hw/rtl/rational_arithmetic_unit_macros.svh
// Assertion helper macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int WORD_BITS = 32;
   localparam int WIDE_BITS = 2 * WORD_BITS;
   localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4,
      OP_NRM = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]                  req_type;
      logic signed [WORD_BITS-1:0] a_num;
      logic signed [WORD_BITS-1:0] a_den;
      logic signed [WORD_BITS-1:0] b_num;
      logic signed [WORD_BITS-1:0] b_den;
   } req_type_t_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_num;
      logic [WORD_BITS-2:0]        res_den;
      logic                        is_less;
      logic                        is_equal;
      logic                        overflow;
   } rsp_type;

   // command and status between sequencer and divider
   typedef struct packed {
      logic                 start;
      logic [WIDE_BITS-1:0] dividend;
      logic [WIDE_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [WIDE_BITS-1:0] quotient;
      logic [WIDE_BITS-1:0] remainder;
   } div_sts_type;
endpackage

FILE: hw/rtl/rau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface rau_req_if;
   import rau_pkg::*;
   logic           valid;
   logic           ready;
   req_type_t_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rau_rsp_if;
   import rau_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/rau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_cmd_type cmd,
   output rau_pkg::div_sts_type sts
);
   import rau_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIDE_BITS-1:0] quo_ff, quo_in;
   logic [WIDE_BITS-1:0] rem_ff, rem_in;
   logic [WIDE_BITS-1:0] dsr_ff, dsr_in;
   logic [WIDE_BITS:0]   trial;

   // start load or one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[WIDE_BITS-1]} - {1'b0, dsr_ff};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(WIDE_BITS);
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         if (!trial[WIDE_BITS]) begin
            rem_in = trial[WIDE_BITS-1:0];
         end else begin
            rem_in = {rem_ff[WIDE_BITS-2:0], quo_ff[WIDE_BITS-1]};
         end
         quo_in = {quo_ff[WIDE_BITS-2:0], ~trial[WIDE_BITS]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;
endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Sequence: each gcd reduction runs Euclid remainder steps on the divider, then divides
// numerator and denominator by the gcd; a special operand (zero or zero denominator) skips it.
// Compare and normalize run two reductions, multiply and divide three, add and subtract four.
// Throughput: one transaction at a time on the shared 64-bit bit-serial divider.
// Reset: synchronous, active high; clears sequencer, valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational add/sub/mul/div/compare/normalize with GCD-reduced results.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"
module rational_arithmetic_unit (
   input logic  clock,
   input logic  reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;
   localparam int D = WIDE_BITS;
   localparam logic [D-1:0] LIM = D'((64'd1 << (W - 1)) - 64'd1);

   typedef enum logic [3:0] {
      S_IDLE, S_CANA, S_CANB, S_OPER, S_DGCD, S_MUL1, S_MUL2, S_FIN,
      S_GCD, S_GWAIT, S_RED1, S_RW1, S_RED2, S_RW2, S_OUT
   } state_type;

   state_type            state_ff;
   logic [2:0]           op_ff;
   logic signed [W-1:0]  in_bn_ff, in_bd_ff;
   logic signed [D-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   // generic canonicalizer operands
   logic signed [D-1:0]  cn_ff, cd_ff;
   logic                 neg_ff;
   logic [D-1:0]         gm_ff, gn_ff, g_ff, un_ff, ud_ff;
   logic                 ovf_ff;
   logic                 lt_ff, eq_ff;
   logic [1:0]           phase_ff;   // 0 canon A, 1 canon B, 2 result, 3 den gcd
   logic signed [D-1:0]  t1_ff, t2_ff;
   logic                 rv_ff;
   rsp_type              rp_ff;
   div_cmd_type          cmd;
   div_sts_type          sts;
   // two shared 32x32 multipliers; canonical values always fit one word
   logic signed [W-1:0]  m0_x, m0_y, m1_x, m1_y;
   logic signed [D-1:0]  prod0, prod1;

   rau_divider u_div (.clock(clock), .reset(reset), .cmd(cmd), .sts(sts));

   function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
      mag = v[D-1] ? D'(-v) : D'(v);
   endfunction

   function automatic logic signed [D-1:0] sgnv(input logic signed [D-1:0] v);
      sgnv = v[D-1] ? -D'(1) : ((v == '0) ? D'(0) : D'(1));
   endfunction

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.payload = rp_ff;

   always_comb begin
      cmd.start    = 1'b0;
      cmd.dividend = gm_ff;
      cmd.divisor  = gn_ff;
      unique case (state_ff)
         S_GCD:  cmd.start = (gn_ff != '0);
         S_RED1: begin
            cmd.start = 1'b1; cmd.dividend = un_ff; cmd.divisor = g_ff;
         end
         S_RED2: begin
            cmd.start = 1'b1; cmd.dividend = ud_ff; cmd.divisor = g_ff;
         end
         default: ;
      endcase
   end

   // multiplier operand select: cross terms in S_OPER, sum terms in S_MUL1/S_MUL2
   always_comb begin
      m0_x = W'(an_ff);
      m0_y = (op_ff == OP_MUL) ? W'(bn_ff) : W'(bd_ff);
      m1_x = W'(ad_ff);
      m1_y = (op_ff == OP_MUL) ? W'(bd_ff) : W'(bn_ff);
      unique case (state_ff)
         S_MUL1: begin
            m0_y = W'(t1_ff); m1_x = W'(t2_ff); m1_y = W'(bn_ff);
         end
         S_MUL2: begin
            m0_x = W'(ad_ff); m0_y = W'(t1_ff);
         end
         default: ;
      endcase
   end

   assign prod0 = D'(m0_x) * D'(m0_y);
   assign prod1 = D'(m1_x) * D'(m1_y);

   // sequencer: canonicalize a, b, operate, canonicalize result (compare and normalize skip the result step)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               op_ff    <= req.payload.req_type;
               cn_ff    <= D'(req.payload.a_num);
               cd_ff    <= D'(req.payload.a_den);
               in_bn_ff <= req.payload.b_num;
               in_bd_ff <= req.payload.b_den;
               ovf_ff   <= 1'b0;
               lt_ff    <= 1'b0;
               eq_ff    <= 1'b0;
               phase_ff <= 2'd0;
               state_ff <= S_CANA;
            end
            S_CANA: begin
               // canonical special or setup gcd
               if (cd_ff == '0) begin
                  an_ff <= sgnv(cn_ff); ad_ff <= '0; state_ff <= S_FIN;
               end else if (cn_ff == '0) begin
                  an_ff <= '0; ad_ff <= D'(1); state_ff <= S_FIN;
               end else begin
                  neg_ff <= cn_ff[D-1] ^ cd_ff[D-1];
                  un_ff <= mag(cn_ff); ud_ff <= mag(cd_ff);
                  gm_ff <= mag(cn_ff); gn_ff <= mag(cd_ff);
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               if (gn_ff == '0) begin
                  g_ff <= gm_ff; state_ff <= S_RED1;
               end else begin
                  state_ff <= S_GWAIT;
               end
            end
            S_GWAIT: if (sts.done) begin
               gm_ff <= gn_ff; gn_ff <= sts.remainder; state_ff <= S_GCD;
            end
            S_RED1: state_ff <= S_RW1;
            S_RW1: if (sts.done) begin un_ff <= sts.quotient; state_ff <= S_RED2; end
            S_RED2: state_ff <= S_RW2;
            S_RW2: if (sts.done) begin
               if (phase_ff == 2'd3) begin
                  // denominator gcd done: g_ff = gcd(ad,bd), un_ff = ad/g, sts.quotient = bd/g
                  state_ff <= S_MUL1;
                  t1_ff <= sts.quotient;           // bd/g
                  t2_ff <= un_ff;                  // ad/g
               end else if (un_ff > LIM || sts.quotient > LIM) begin
                  ovf_ff <= 1'b1; an_ff <= '0; ad_ff <= '0; state_ff <= S_FIN;
               end else begin
                  an_ff <= neg_ff ? D'(-un_ff) : un_ff; ad_ff <= sts.quotient;
                  state_ff <= S_FIN;
               end
            end
            S_MUL1: begin
               // cross terms of sum with reduced denominators
               cn_ff <= prod0;
               cd_ff <= prod1;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               cn_ff <= cn_ff + cd_ff;
               cd_ff <= prod0;
               phase_ff <= 2'd2;
               state_ff <= S_CANA;
            end
            S_FIN: begin
               unique case (phase_ff)
                  2'd0: begin
                     ad_ff <= ad_ff;
                     bn_ff <= an_ff; bd_ff <= ad_ff;   // stash a
                     cn_ff <= D'(in_bn_ff); cd_ff <= D'(in_bd_ff);
                     phase_ff <= 2'd1;
                     state_ff <= S_CANA;
                  end
                  2'd1: begin
                     // an/ad now hold b; swap so an/ad = a, bn/bd = b
                     an_ff <= bn_ff; ad_ff <= bd_ff;
                     bn_ff <= an_ff; bd_ff <= ad_ff;
                     state_ff <= S_OPER;
                  end
                  2'd3: state_ff <= S_OPER;
                  default: begin
                     rp_ff.res_num  <= W'(an_ff);
                     rp_ff.res_den  <= (W-1)'(ad_ff);
                     rp_ff.is_less  <= 1'b0;
                     rp_ff.is_equal <= 1'b0;
                     rp_ff.overflow <= ovf_ff;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_OPER: begin
               unique case (op_ff)
                  OP_ADD, OP_SUB: begin
                     if (op_ff == OP_SUB) bn_ff <= -bn_ff;
                     if (ad_ff == '0 && bd_ff == '0) begin
                        cn_ff <= (an_ff == '0 || bn_ff == '0) ? D'(0) :
                                 an_ff + ((op_ff == OP_SUB) ? -bn_ff : bn_ff);
                        cd_ff <= '0; phase_ff <= 2'd2; state_ff <= S_CANA;
                     end else if (ad_ff == '0 || bd_ff == '0) begin
                        cn_ff <= (ad_ff == '0) ? an_ff :
                                 ((op_ff == OP_SUB) ? -bn_ff : bn_ff);
                        cd_ff <= '0; phase_ff <= 2'd2; state_ff <= S_CANA;
                     end else begin
                        // gcd of denominators, then quotients via reduce steps
                        phase_ff <= 2'd3;
                        gm_ff <= ad_ff; gn_ff <= bd_ff;
                        un_ff <= ad_ff; ud_ff <= bd_ff;
                        state_ff <= S_GCD;
                     end
                  end
                  OP_MUL, OP_DIV: begin
                     cn_ff <= prod0; cd_ff <= prod1;
                     phase_ff <= 2'd2; state_ff <= S_CANA;
                  end
                  OP_CMP: begin
                     cn_ff <= prod0; cd_ff <= prod1;
                     eq_ff <= (an_ff == bn_ff) && (ad_ff == bd_ff);
                     state_ff <= S_DGCD;
                  end
                  OP_NRM: begin
                     cn_ff <= '0; cd_ff <= '0; phase_ff <= 2'd2; state_ff <= S_FIN;
                  end
                  default: begin
                     an_ff <= '0; ad_ff <= '0; ovf_ff <= 1'b0;
                     phase_ff <= 2'd2; state_ff <= S_FIN;
                  end
               endcase
            end
            S_DGCD: begin
               // compare decision on registered cross products, or on numerators when both denominators are zero
               if (ad_ff == '0 && bd_ff == '0)
                  lt_ff <= (an_ff != '0) && (bn_ff != '0) && (an_ff < bn_ff);
               else
                  lt_ff <= cn_ff < cd_ff;
               rp_ff.res_num  <= '0;
               rp_ff.res_den  <= '0;
               rp_ff.overflow <= ovf_ff;
               state_ff <= S_OUT;
            end
            S_OUT: if (!rv_ff) begin
               if (op_ff == OP_CMP) begin
                  rp_ff.is_less <= lt_ff; rp_ff.is_equal <= eq_ff;
               end
               rv_ff    <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `RAU_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE, "ready outside idle")
   `RAU_ASSERT_NEXT(a_accept_busy, clock, reset, req.valid && req.ready, !req.ready, "accept while busy")
   `RAU_ASSERT_IMP(a_cmp_den, clock, reset, rsp.valid && rsp.payload.is_less, rsp.payload.res_den == '0, "compare with den")
endmodule
